// ----- hdl/move_to_front_coder_macros.svh -----
// Assertion macros for the move-to-front coder.
`ifndef MOVE_TO_FRONT_CODER_MACROS_SVH
`define MOVE_TO_FRONT_CODER_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising edge outside reset.
`define MTF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define MTF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MTF_ASSERT_NOW(lbl, ante, cons, msg)
`define MTF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/mtf_pkg.sv -----
// Shared types and constants of the move-to-front coder.
`timescale 1ns / 1ps
package mtf_pkg;
	localparam int SYM_W = 5;
	localparam int VALUE_W = 8;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [VALUE_W-1:0] FIRST_LETTER = 8'h61;
	localparam logic REG_DECODE_MODE = 1'b0;

	typedef logic [SYM_W-1:0] sym_t;
	typedef logic [VALUE_W-1:0] value_t;

	// Control broadcast from the top level to every cell.
	typedef struct packed {
		logic   commit;
		logic   start;
		logic   decode;
		value_t value;
	} cell_ctrl_t;
endpackage

// ----- hdl/mtf_in_if.sv -----
// Input channel: one symbol word with its start flag.
`timescale 1ns / 1ps
interface mtf_in_if import mtf_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   start_block;
	value_t in_value;

	modport source(output valid, output start_block, output in_value, input ready);
	modport sink(input valid, input start_block, input in_value, output ready);
endinterface

// ----- hdl/mtf_out_if.sv -----
// Output channel: one coded word with its error flag.
`timescale 1ns / 1ps
interface mtf_out_if import mtf_pkg::*; ();
	logic   valid;
	logic   ready;
	value_t out_value;
	logic   bad_input;

	modport source(output valid, output out_value, output bad_input, input ready);
	modport sink(input valid, input out_value, input bad_input, output ready);
endinterface

// ----- hdl/move_to_front_coder.sv -----
// Top level of the move-to-front coder: cell chain, output register and APB register.
`timescale 1ns / 1ps
// Move-to-front coder over the first ALPHABET_SIZE lower-case letters.
// Words arrive on in_ch (start_block, in_value) and leave on out_ch
// (out_value, bad_input), both valid/ready; a word moves at a rising edge
// where valid and ready are both high.
// In encode mode a letter byte gives its current list position; in decode
// mode a position gives the letter byte found there. Either way the symbol
// then moves to the front of the list. A set start_block restores the
// a..z order before the word is coded. A byte that is not a letter of the
// alphabet, or a position of ALPHABET_SIZE or more, gives 0 with bad_input
// set and leaves the list alone (a restore still happens).
// Each list position is one cell; all cells compare against the input word
// at once, the hit ripples toward the front as a shift enable, and every
// cell at or before the hit loads its left neighbor in the same cycle.
// out_ch.valid rises in the cycle after a word is accepted, and a new word
// is taken every cycle while no result waits or out_ch.ready is high; the
// compare and shift over the whole chain is combinational. While a result
// waits on a stalled receiver, in_ch.ready stays low until the receiver takes it.
// Reset restores the a..z order, clears the output register and sets
// encode mode. decode_mode lies at byte address 0 of the APB port.
`include "move_to_front_coder_macros.svh"
module move_to_front_coder import mtf_pkg::*; #(
	parameter int ALPHABET_SIZE = 26
) (
	input  logic                 clk,
	input  logic                 arst_n,
	mtf_in_if.sink               in_ch,
	mtf_out_if.source            out_ch,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready
);
	localparam value_t LAST_POS = VALUE_W'(ALPHABET_SIZE);

	logic       decode_mode_q;
	logic       out_valid_q;
	value_t     out_value_q;
	logic       bad_input_q;
	logic       accept;
	cell_ctrl_t ctrl;
	sym_t       eff_sym [ALPHABET_SIZE];
	sym_t       cur_sym [ALPHABET_SIZE];
	sym_t       left_sym [ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0] hit;
	logic [ALPHABET_SIZE:0]   shift_chain;
	sym_t       moved_sym;
	value_t     hit_pos;
	logic       any_hit;

	// Configuration register: written in the APB access phase, no wait states.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DECODE_MODE) ? PDATA_W'(decode_mode_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DECODE_MODE)) begin
			decode_mode_q <= pwdata[0];
		end
	end

	// The output register frees the input side as soon as the result is taken.
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept = in_ch.valid && in_ch.ready;

	assign ctrl.commit = accept;
	assign ctrl.start = in_ch.start_block;
	assign ctrl.decode = decode_mode_q;
	assign ctrl.value = in_ch.in_value;

	// The shift enable enters empty behind the last cell.
	assign shift_chain[ALPHABET_SIZE] = 1'b0;

	for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
		if (i == 0) begin : g_front
			assign left_sym[i] = moved_sym;
		end else begin : g_rest
			assign left_sym[i] = eff_sym[i-1];
		end
		mtf_cell #(
			.INDEX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.left_sym (left_sym[i]),
			.shift_in (shift_chain[i+1]),
			.eff_sym  (eff_sym[i]),
			.sym      (cur_sym[i]),
			.hit      (hit[i]),
			.shift_out(shift_chain[i])
		);
	end

	// At most one cell hits, so the position and symbol are plain OR trees.
	always_comb begin
		moved_sym = '0;
		hit_pos = '0;
		for (int i = 0; i < ALPHABET_SIZE; i++) begin
			if (hit[i]) begin
				moved_sym = moved_sym | eff_sym[i];
				hit_pos = hit_pos | VALUE_W'(i);
			end
		end
	end

	assign any_hit = |hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_input_q <= 1'b0;
			out_value_q <= '0;
		end else if (accept) begin
			bad_input_q <= !any_hit;
			if (!any_hit) begin
				out_value_q <= '0;
			end else if (decode_mode_q) begin
				out_value_q <= FIRST_LETTER + VALUE_W'(moved_sym);
			end else begin
				out_value_q <= hit_pos;
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.out_value = out_value_q;
	assign out_ch.bad_input = bad_input_q;

	// Distinct symbols in the list mean no two cells can hit on one word.
	`MTF_ASSERT_NOW(a_single_hit, 1'b1, $onehot0(hit), "more than one cell hit")
	// Every in-range position is decodable.
	`MTF_ASSERT_NEXT(a_decode_in_range, accept && decode_mode_q && (in_ch.in_value < LAST_POS),
		!bad_input_q, "in-range position flagged as bad")
	// A decoded letter always ends up at the front of the list.
	`MTF_ASSERT_NEXT(a_front_is_moved, accept && decode_mode_q && any_hit,
		out_value_q == (FIRST_LETTER + VALUE_W'(cur_sym[0])), "decoded letter not at front")
	// A word that hits nothing leaves a zero result.
	`MTF_ASSERT_NEXT(a_bad_gives_zero, accept && !any_hit,
		bad_input_q && (out_value_q == '0), "error result not zero")
endmodule

// ----- hdl/mtf_cell.sv -----
// One list position of the move-to-front coder: holds a symbol and shifts from its neighbor.
`timescale 1ns / 1ps
module mtf_cell import mtf_pkg::*; #(
	parameter int INDEX = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  sym_t       left_sym,
	input  logic       shift_in,
	output sym_t       eff_sym,
	output sym_t       sym,
	output logic       hit,
	output logic       shift_out
);
	localparam sym_t HOME_SYM = SYM_W'(INDEX);
	localparam value_t HOME_POS = VALUE_W'(INDEX);

	sym_t sym_q;

	// The start flag sees the initial order in place of the stored symbol.
	assign eff_sym = ctrl.start ? HOME_SYM : sym_q;
	assign sym = sym_q;

	always_comb begin
		if (ctrl.decode) begin
			hit = (ctrl.value == HOME_POS);
		end else begin
			hit = (ctrl.value == (FIRST_LETTER + VALUE_W'(eff_sym)));
		end
	end

	// A cell shifts when the hit lies at its place or further back.
	assign shift_out = shift_in | hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q <= HOME_SYM;
		end else if (ctrl.commit) begin
			sym_q <= shift_out ? left_sym : eff_sym;
		end
	end
endmodule
